@@ hdl/lbbc_pkg.sv @@
// Package for the LRU block buffer cache: function codes, status codes,
// controller state type and datapath command/status structs. No dependencies.
package lbbc_pkg;

   localparam int FUNC_W   = 2;
   localparam int DEV_W    = 8;
   localparam int BLK_W    = 32;
   localparam int SLOT_W   = 5;
   localparam int TICK_W   = 32;
   localparam int STATUS_W = 2;
   localparam int COUNT_W  = 8;
   localparam logic [COUNT_W-1:0] COUNT_MAX = 8'hFF;
   localparam logic [TICK_W-1:0]  STAMP_MAX = 32'hFFFF_FFFF;

   typedef enum logic [FUNC_W-1:0] {
      FUNC_GET     = 2'd0,
      FUNC_RELEASE = 2'd1,
      FUNC_PIN     = 2'd2,
      FUNC_UNPIN   = 2'd3
   } func_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK      = 2'd0,
      ST_NO_FREE = 2'd1,
      ST_UNDER   = 2'd2,
      ST_OVER    = 2'd3
   } status_type;

   typedef enum logic [3:0] {
      S_IDLE = 4'b0001,
      S_SCAN = 4'b0010,
      S_ACT  = 4'b0100,
      S_OUT  = 4'b1000
   } state_type;

   // controller -> datapath
   typedef struct packed {
      logic load;   // capture the incoming item
      logic scan;   // clear scan results and run one scan step
      logic act;    // apply the update and form the result
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic scan_done;
   } stat_type;

endpackage

@@ hdl/lru_block_buffer_cache_top.sv @@
// LRU block buffer cache top level: controller plus datapath.
// Each item is captured, scanned over the slots 8 lanes at a time, then updated;
// a new item is accepted only after the previous result has been taken.
// Reset: synchronous, clears all slot tags, counts, valid marks and stamps at once.
// Depends on lbbc_pkg, lbbc_ctrl, lbbc_dpath.
module lru_block_buffer_cache_top
   import lbbc_pkg::*;
#(
   parameter int NUM_SLOTS = 32
)
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // func[1:0], device_id[9:2], block_number[41:10], slot_index[46:42],
   // tick_now[78:47], zero fill
   input  logic [79:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // slot[4:0], hit[5], needs_fill[6], status[8:7], zero fill
   output logic [15:0] rsp_tdata
);

   cmd_type  cmd;
   stat_type stat;
   logic [SLOT_W-1:0]   o_slot;
   logic                o_hit, o_fill;
   logic [STATUS_W-1:0] o_status;

   lbbc_ctrl u_ctrl (
      .clock, .reset, .req_tvalid, .req_tready, .rsp_tvalid, .rsp_tready,
      .stat, .cmd
   );

   lbbc_dpath #(.NUM_SLOTS(NUM_SLOTS)) u_dpath (
      .clock, .reset, .cmd, .stat,
      .in_func (req_tdata[1:0]),
      .in_dev  (req_tdata[9:2]),
      .in_blk  (req_tdata[41:10]),
      .in_idx  (req_tdata[46:42]),
      .in_tick (req_tdata[78:47]),
      .out_slot(o_slot), .out_hit(o_hit), .out_fill(o_fill), .out_status(o_status)
   );

   assign rsp_tdata = {7'd0, o_status, o_fill, o_hit, o_slot};

   // no new item while a result is pending
   a_excl: assert property (@(posedge clock) disable iff (reset)
      !(req_tready && rsp_tvalid)) else $error("ready while result pending");
   // a fill is only requested by a get that is not a hit-overflow
   a_fill: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && o_fill |-> o_status == ST_OK) else $error("fill with bad status");
   // hit only with ok or overflow status
   a_hit: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && o_hit |-> (o_status == ST_OK || o_status == ST_OVER))
      else $error("hit with bad status");

endmodule

@@ hdl/lbbc_ctrl.sv @@
// Controller state machine for the LRU block buffer cache.
// Depends on lbbc_pkg.
module lbbc_ctrl
   import lbbc_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     req_tvalid,
   output logic     req_tready,
   output logic     rsp_tvalid,
   input  logic     rsp_tready,
   input  stat_type stat,
   output cmd_type  cmd
);

   state_type state_ff, state_in;

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = (state_ff == S_OUT);

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            cmd.scan = 1'b1;
            if (stat.scan_done) state_in = S_ACT;
         end
         S_ACT: begin
            cmd.act  = 1'b1;
            state_in = S_OUT;
         end
         S_OUT: begin
            if (rsp_tready) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_IDLE;
      else       state_ff <= state_in;
   end

endmodule

@@ hdl/lbbc_dpath.sv @@
// Datapath for the LRU block buffer cache: slot tables, a scan over the slots
// in groups of LANES per cycle for tag match and LRU victim, and the update.
// Depends on lbbc_pkg.
module lbbc_dpath
   import lbbc_pkg::*;
#(
   parameter int NUM_SLOTS = 32
)
(
   input  logic                   clock,
   input  logic                   reset,
   input  cmd_type                cmd,
   output stat_type               stat,
   input  logic [FUNC_W-1:0]      in_func,
   input  logic [DEV_W-1:0]       in_dev,
   input  logic [BLK_W-1:0]       in_blk,
   input  logic [SLOT_W-1:0]      in_idx,
   input  logic [TICK_W-1:0]      in_tick,
   output logic [SLOT_W-1:0]      out_slot,
   output logic                   out_hit,
   output logic                   out_fill,
   output logic [STATUS_W-1:0]    out_status
);

   localparam int IW    = $clog2(NUM_SLOTS);
   localparam int LANES = 8;
   localparam int NGRP  = (NUM_SLOTS + LANES - 1) / LANES;
   localparam int GW    = (NGRP > 1) ? $clog2(NGRP) : 1;

   // slot state in flip-flops (reset values are zero)
   logic [DEV_W-1:0]   tdev_ff   [NUM_SLOTS];
   logic [BLK_W-1:0]   tblk_ff   [NUM_SLOTS];
   logic [COUNT_W-1:0] cnt_ff    [NUM_SLOTS];
   logic               vld_ff    [NUM_SLOTS];
   logic [TICK_W-1:0]  stamp_ff  [NUM_SLOTS];

   // captured item
   logic [FUNC_W-1:0] func_ff;
   logic [DEV_W-1:0]  dev_ff;
   logic [BLK_W-1:0]  blk_ff;
   logic [SLOT_W-1:0] idx_ff;
   logic [TICK_W-1:0] tick_ff;

   // scan results
   logic [GW-1:0]     grp_ff;
   logic              hit_ff;
   logic [IW-1:0]     hslot_ff;
   logic              free_ff;
   logic [IW-1:0]     vslot_ff;
   logic [TICK_W-1:0] vstamp_ff;

   // one group scan step: lanes in order, first match and strict-less stamp
   logic              hit_in, free_in;
   logic [IW-1:0]     hslot_in, vslot_in;
   logic [TICK_W-1:0] vstamp_in;
   logic              first;

   always_comb begin
      int s;
      logic [IW-1:0] si;
      first     = (grp_ff == '0);
      hit_in    = first ? 1'b0 : hit_ff;
      hslot_in  = hslot_ff;
      free_in   = first ? 1'b0 : free_ff;
      vslot_in  = vslot_ff;
      vstamp_in = vstamp_ff;
      for (int l = 0; l < LANES; l++) begin
         s  = int'(grp_ff) * LANES + l;
         si = IW'(s);
         if (s < NUM_SLOTS) begin
            if (!hit_in && tdev_ff[si] == dev_ff && tblk_ff[si] == blk_ff) begin
               hit_in   = 1'b1;
               hslot_in = si;
            end
            if (cnt_ff[si] == '0 && (!free_in || stamp_ff[si] < vstamp_in)) begin
               free_in   = 1'b1;
               vslot_in  = si;
               vstamp_in = stamp_ff[si];
            end
         end
      end
   end

   assign stat.scan_done = (grp_ff == GW'(NGRP - 1));

   logic idx_ok;
   logic [IW-1:0] nidx;
   assign idx_ok = (32'(idx_ff) < 32'(NUM_SLOTS));
   assign nidx   = IW'(idx_ff);

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         func_ff <= in_func;
         dev_ff  <= in_dev;
         blk_ff  <= in_blk;
         idx_ff  <= in_idx;
         tick_ff <= in_tick;
      end
      if (reset) begin
         grp_ff <= '0;
      end else if (cmd.scan) begin
         grp_ff <= stat.scan_done ? '0 : grp_ff + 1'b1;
      end
      if (cmd.scan) begin
         hit_ff    <= hit_in;
         hslot_ff  <= hslot_in;
         free_ff   <= free_in;
         vslot_ff  <= vslot_in;
         vstamp_ff <= vstamp_in;
      end
   end

   // update and result
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_SLOTS; i++) begin
            tdev_ff[i]  <= '0;
            tblk_ff[i]  <= '0;
            cnt_ff[i]   <= '0;
            vld_ff[i]   <= 1'b0;
            stamp_ff[i] <= '0;
         end
      end else if (cmd.act) begin
         out_hit    <= 1'b0;
         out_fill   <= 1'b0;
         out_status <= ST_OK;
         out_slot   <= idx_ff;
         if (func_ff == FUNC_GET) begin
            if (hit_ff) begin
               out_slot <= SLOT_W'(hslot_ff);
               out_hit  <= 1'b1;
               if (cnt_ff[hslot_ff] == COUNT_MAX) begin
                  out_status <= ST_OVER;
               end else begin
                  cnt_ff[hslot_ff] <= cnt_ff[hslot_ff] + 1'b1;
                  out_fill         <= ~vld_ff[hslot_ff];
                  vld_ff[hslot_ff] <= 1'b1;
               end
            end else if (free_ff) begin
               out_slot          <= SLOT_W'(vslot_ff);
               out_fill          <= 1'b1;
               tdev_ff[vslot_ff] <= dev_ff;
               tblk_ff[vslot_ff] <= blk_ff;
               cnt_ff[vslot_ff]  <= COUNT_W'(1);
               vld_ff[vslot_ff]  <= 1'b1;
            end else begin
               out_slot   <= '0;
               out_status <= ST_NO_FREE;
            end
         end else if (idx_ok) begin
            if (func_ff == FUNC_PIN) begin
               if (cnt_ff[nidx] == COUNT_MAX) out_status <= ST_OVER;
               else cnt_ff[nidx] <= cnt_ff[nidx] + 1'b1;
            end else if (cnt_ff[nidx] == '0) begin
               out_status <= ST_UNDER;
            end else begin
               cnt_ff[nidx] <= cnt_ff[nidx] - 1'b1;
               if (func_ff == FUNC_RELEASE && cnt_ff[nidx] == COUNT_W'(1))
                  stamp_ff[nidx] <= tick_ff;
            end
         end
      end
   end

endmodule
